### rtl/conv2d_sliding_window_mac_core_assert.svh
// Assertion macros for the 2-D sliding-window MAC core.
// Included by the top level; the macros expand to nothing under SYNTHESIS.
`ifndef CONV2D_SLIDING_WINDOW_MAC_CORE_ASSERT_SVH
`define CONV2D_SLIDING_WINDOW_MAC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define C2D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define C2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define C2D_ASSERT_NOW(lbl, ante, cons)
`define C2D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/c2d_pkg.sv
// Shared types and codes for the 2-D sliding-window MAC core.
// No dependencies.
package c2d_pkg;

  localparam logic [1:0] OP_LOAD_KERNEL = 2'd0;
  localparam logic [1:0] OP_LOAD_IMAGE  = 2'd1;
  localparam logic [1:0] OP_READ        = 2'd2;
  localparam logic [1:0] OP_RESTART     = 2'd3;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_IMAGE_ROWS  = 3'd1;
  localparam logic [2:0] REG_IMAGE_COLS  = 3'd2;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd3;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd4;

  localparam logic [1:0] MODE_FULL     = 2'd0;
  localparam logic [1:0] MODE_SAME     = 2'd1;
  localparam logic [1:0] MODE_VALID    = 2'd2;
  localparam logic [1:0] MODE_ALT_SAME = 2'd3;  // behaves as same

  localparam int FRAC_BITS = 14;
  localparam int ACC_W     = 48;
  localparam int CFG_W     = 7;

  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic step;      // issue one kernel tap
    logic load_out;  // move the finished pixel into the output register
  } c2d_cmd_t;

  typedef struct packed {
    logic empty;     // pending read has no pixel
    logic tap_last;  // tap being issued is the last of the window
    logic out_full;  // output register holds an untaken result
  } c2d_sts_t;

endpackage

### rtl/conv2d_sliding_window_mac_core.sv
// Top level of the 2-D sliding-window MAC core (correlation, full/same/valid).
// Depends on c2d_pkg, c2d_ctrl, c2d_dp and the assertion macro header.
//
// Usage: write the size and mode registers through cfg_* while idle, then send
// kernel words and image samples, row-major, as in_ transfers with op load
// kernel or load image on in_tuser. Each read transfer yields one output pixel
// on out_, row-major; restart clears the load counts and the output position.
// out_tuser high marks an empty read (image not fully loaded or no pixel left),
// out_tlast marks the final pixel.
// A read walks the kernel window with one multiply-accumulate per cycle, then
// passes through the store read, product and accumulate stages and the output
// load; an empty read skips the walk. Only one read is in work at a time;
// in_tready is low while it runs.
// The result sits in an output register; while the receiver stalls, the block
// holds the finished pixel and waits before writing the next one.
// Reset clears counters, position and registers to their defaults; the image
// and kernel stores are not cleared and must be loaded before use.
`include "conv2d_sliding_window_mac_core_assert.svh"
module conv2d_sliding_window_mac_core import c2d_pkg::*; #(
  parameter int MAX_IMAGE_ROWS = 64,
  parameter int MAX_IMAGE_COLS = 64,
  parameter int MAX_KERNEL_DIM = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // value[15:0]
  input  logic [1:0]       in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // result_value[31:0]
  output logic             out_tlast,
  output logic             out_tuser   // empty_res[0]
);

  c2d_cmd_t cmd;
  c2d_sts_t sts;

  c2d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  c2d_dp #(
    .MAX_IMAGE_ROWS (MAX_IMAGE_ROWS),
    .MAX_IMAGE_COLS (MAX_IMAGE_COLS),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_value   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `C2D_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_tvalid || out_tready)
  `C2D_ASSERT_NOW(a_empty_is_zero, out_tvalid && out_tuser, out_tdata == 32'd0 && !out_tlast)
  `C2D_ASSERT_NEXT(a_read_busy, in_tvalid && in_tready && in_tuser == OP_READ, !in_tready)

endmodule

### rtl/c2d_ctrl.sv
// Sequencer for the 2-D sliding-window MAC core.
// Depends on c2d_pkg; drives the datapath through c2d_cmd_t.
module c2d_ctrl import c2d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_op,
  output logic       in_tready,
  input  logic       out_tready,
  input  c2d_sts_t   sts,
  output c2d_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUTW  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    drain_nxt    = drain_r;
    cmd.accept   = in_tvalid && in_tready;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && in_op == OP_READ) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (sts.empty) begin
          state_nxt = ST_OUTW;
        end else begin
          cmd.step = 1'b1;
          if (sts.tap_last) begin
            state_nxt = ST_DRAIN;
            drain_nxt = 1'b0;
          end
        end
      end
      ST_DRAIN: begin
        // wait out memory read and product stages
        drain_nxt = 1'b1;
        if (drain_r) state_nxt = ST_OUTW;
      end
      ST_OUTW: begin
        if (!sts.out_full || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

### rtl/c2d_dp.sv
// Datapath of the 2-D sliding-window MAC core: registers, stores, MAC, output.
// Depends on c2d_pkg; sequenced by c2d_ctrl.
module c2d_dp import c2d_pkg::*; #(
  parameter int MAX_IMAGE_ROWS = 64,
  parameter int MAX_IMAGE_COLS = 64,
  parameter int MAX_KERNEL_DIM = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  c2d_cmd_t           cmd,
  output c2d_sts_t           sts,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_value,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [31:0]        out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  localparam int MAXD   = (MAX_IMAGE_ROWS > MAX_IMAGE_COLS) ? MAX_IMAGE_ROWS : MAX_IMAGE_COLS;
  localparam int DW0    = $clog2(MAXD + MAX_KERNEL_DIM + 1);
  localparam int DW     = (DW0 < 8) ? 8 : DW0;
  localparam int KW     = $clog2(MAX_KERNEL_DIM + 1);
  localparam int KDEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int KCW    = $clog2(KDEPTH + 1);
  localparam int IDEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
  localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  localparam int LCW    = $clog2(IDEPTH + 1);

  // configuration registers
  logic [1:0]       mode_r;
  logic [CFG_W-1:0] irows_r, icols_r;
  logic [2:0]       krows_r, kcols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SAME;
      irows_r <= CFG_W'(64);
      icols_r <= CFG_W'(64);
      krows_r <= 3'd3;
      kcols_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:        mode_r  <= cfg_wdata[1:0];
        REG_IMAGE_ROWS:  irows_r <= cfg_wdata;
        REG_IMAGE_COLS:  icols_r <= cfg_wdata;
        REG_KERNEL_ROWS: krows_r <= cfg_wdata[2:0];
        REG_KERNEL_COLS: kcols_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [DW-1:0] ir, ic, kr, kc, orows, ocols, pr, pc;
  logic [1:0]    m;

  assign ir = (irows_r == '0) ? DW'(1) :
              ((DW'(irows_r) > DW'(MAX_IMAGE_ROWS)) ? DW'(MAX_IMAGE_ROWS) : DW'(irows_r));
  assign ic = (icols_r == '0) ? DW'(1) :
              ((DW'(icols_r) > DW'(MAX_IMAGE_COLS)) ? DW'(MAX_IMAGE_COLS) : DW'(icols_r));
  assign kr = (krows_r == '0) ? DW'(1) :
              ((DW'(krows_r) > DW'(MAX_KERNEL_DIM)) ? DW'(MAX_KERNEL_DIM) : DW'(krows_r));
  assign kc = (kcols_r == '0) ? DW'(1) :
              ((DW'(kcols_r) > DW'(MAX_KERNEL_DIM)) ? DW'(MAX_KERNEL_DIM) : DW'(kcols_r));
  assign m  = (mode_r == MODE_ALT_SAME) ? MODE_SAME : mode_r;

  always_comb begin
    case (m)
      MODE_FULL: begin
        orows = ir + kr - DW'(1);
        ocols = ic + kc - DW'(1);
        pr    = kr - DW'(1);
        pc    = kc - DW'(1);
      end
      MODE_VALID: begin
        orows = (ir >= kr) ? ir - kr + DW'(1) : '0;
        ocols = (ic >= kc) ? ic - kc + DW'(1) : '0;
        pr    = '0;
        pc    = '0;
      end
      default: begin
        orows = ir;
        ocols = ic;
        pr    = (kr - DW'(1)) >> 1;
        pc    = (kc - DW'(1)) >> 1;
      end
    endcase
  end

  logic [LCW-1:0] img_total;
  logic [KCW-1:0] ker_total;
  assign img_total = LCW'(ir) * LCW'(ic);
  assign ker_total = KCW'(kr * kc);

  // load counters and output position
  logic [LCW-1:0] img_cnt_r;
  logic [KCW-1:0] ker_cnt_r;
  logic [DW-1:0]  row_r, col_r;
  logic           is_kload, is_iload, is_read, is_restart;

  assign is_kload   = cmd.accept && in_op == OP_LOAD_KERNEL && ker_cnt_r < ker_total;
  assign is_iload   = cmd.accept && in_op == OP_LOAD_IMAGE && img_cnt_r < img_total;
  assign is_read    = cmd.accept && in_op == OP_READ;
  assign is_restart = cmd.accept && in_op == OP_RESTART;

  logic empty_now, last_now;
  assign empty_now = (img_cnt_r < img_total) || (row_r >= orows) || (col_r >= ocols);
  assign last_now  = (row_r + DW'(1) == orows) && (col_r + DW'(1) == ocols);

  logic empty_r, last_r;

  // kernel window walk
  logic [KW-1:0]  k_r, l_r;
  logic [KAW-1:0] ki_r;
  logic [DW-1:0]  rs, cs, rr, cc;
  logic           tap_ok;
  logic [IAW-1:0] img_addr;

  assign sts.tap_last = (DW'(k_r) == kr - DW'(1)) && (DW'(l_r) == kc - DW'(1));
  assign sts.empty    = empty_r;

  assign rs       = row_r + DW'(k_r);
  assign cs       = col_r + DW'(l_r);
  assign rr       = rs - pr;
  assign cc       = cs - pc;
  assign tap_ok   = (rs >= pr) && (cs >= pc) && (rr < ir) && (cc < ic);
  assign img_addr = IAW'(rr) * IAW'(ic) + IAW'(cc);

  logic signed [15:0] imem [IDEPTH];
  logic signed [15:0] kmem [KDEPTH];
  logic signed [15:0] img_q, ker_q;

  always_ff @(posedge clk) begin
    if (is_iload) imem[img_cnt_r[IAW-1:0]] <= in_value;
    img_q <= imem[img_addr];
  end

  always_ff @(posedge clk) begin
    if (is_kload) kmem[ker_cnt_r[KAW-1:0]] <= in_value;
    ker_q <= kmem[ki_r];
  end

  logic               v1_r, v2_r;
  logic signed [31:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    prod_r <= img_q * ker_q;
  end

  // result rounding toward minus infinity, then saturate
  logic signed [ACC_W-1:0] shifted;
  logic [31:0]             sat;
  assign shifted = acc_r >>> FRAC_BITS;
  always_comb begin
    if (shifted[ACC_W-1:31] == '0 || shifted[ACC_W-1:31] == '1) sat = shifted[31:0];
    else if (shifted[ACC_W-1])                                   sat = 32'h8000_0000;
    else                                                         sat = 32'h7FFF_FFFF;
  end

  logic        out_valid_r, out_last_r, out_user_r;
  logic [31:0] out_data_r;

  assign sts.out_full = out_valid_r;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser    = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_cnt_r   <= '0;
      ker_cnt_r   <= '0;
      row_r       <= '0;
      col_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      empty_r     <= 1'b1;
      last_r      <= 1'b0;
      k_r         <= '0;
      l_r         <= '0;
      ki_r        <= '0;
    end else begin
      v1_r <= cmd.step && tap_ok;
      v2_r <= v1_r;
      if (is_kload) ker_cnt_r <= ker_cnt_r + KCW'(1);
      if (is_iload) img_cnt_r <= img_cnt_r + LCW'(1);
      if (is_restart) begin
        ker_cnt_r <= '0;
        img_cnt_r <= '0;
        row_r     <= '0;
        col_r     <= '0;
      end
      if (is_read) begin
        empty_r <= empty_now;
        last_r  <= last_now;
        k_r     <= '0;
        l_r     <= '0;
        ki_r    <= '0;
      end
      if (cmd.step) begin
        ki_r <= ki_r + KAW'(1);
        if (DW'(l_r) == kc - DW'(1)) begin
          l_r <= '0;
          k_r <= k_r + KW'(1);
        end else begin
          l_r <= l_r + KW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (!empty_r) begin
          if (col_r + DW'(1) >= ocols) begin
            col_r <= '0;
            row_r <= row_r + DW'(1);
          end else begin
            col_r <= col_r + DW'(1);
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_read)   acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + ACC_W'(prod_r);
    if (cmd.load_out) begin
      out_data_r <= empty_r ? 32'd0 : sat;
      out_last_r <= empty_r ? 1'b0 : last_r;
      out_user_r <= empty_r;
    end
  end

endmodule
